>>> rtl/ffc_pkg.sv
// Package for the float format converter: function codes and field constants.
// No dependencies.
package ffc_pkg;

    typedef enum logic [1:0] {
        FUNC_S2H  = 2'd0,
        FUNC_H2S  = 2'd1,
        FUNC_S2BF = 2'd2,
        FUNC_BF2S = 2'd3
    } t_func;

    localparam logic [15:0] HALF_INF  = 16'h7C00;
    localparam logic [22:0] SGL_MANT  = 23'h7FFFFF;
    localparam logic [7:0]  SGL_EXP_MAX = 8'hFF;

endpackage

>>> rtl/float_format_converter.sv
// Float format converter top level: binary32 / binary16 / bfloat16.
// Depends on ffc_pkg.
//
// Usage: one input channel (i_valid/o_ready, i_func, i_operand_bits) and one
// output channel (o_valid/i_ready, o_result_bits). Each input beat gives one
// output beat, in order. Functions: 0 binary32->binary16 (truncating),
// 1 binary16->binary32, 2 binary32->bfloat16, 3 bfloat16->binary32.
// Three register stages (decode, shift, assemble); o_valid is the valid bit
// of the assemble stage. Throughput is one beat per cycle while the output
// does not stall. A stall on the output holds each full stage whose later
// stages are all full; a stage takes a new beat whenever it is empty or the
// stage after it advances, so no beat is lost or repeated.
// Reset clears all valid bits; the pipeline is empty and o_ready is high
// after reset.
module float_format_converter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_func,
    input  logic [31:0]          i_operand_bits,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [31:0]          o_result_bits
);
    import ffc_pkg::*;

    // stage valid and advance
    logic r_v1, r_v2, r_v3;
    logic adv1, adv2, adv3;
    assign adv3    = !r_v3 || i_ready;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;
    assign o_valid = r_v3;

    // stage 1: decode
    logic [1:0]  r1_func;
    logic [31:0] r1_x;
    logic [4:0]  r1_sh;
    logic [15:0] r1_base;
    logic [3:0]  r1_p;
    logic [15:0] n1_base;
    logic [4:0]  n1_sh;
    logic [3:0]  n1_p;
    logic [7:0]  e8;
    logic [9:0]  hm;

    always_comb begin
        e8 = i_operand_bits[30:23];
        n1_base = 16'd0;
        n1_sh = 5'd24;
        priority if (e8 < 8'd103) begin
            n1_base = 16'd0;
            n1_sh = 5'd24;
        end else if (e8 < 8'd113) begin
            n1_base = 16'h0400 >> (8'd113 - e8);
            n1_sh = 5'(8'd126 - e8);
        end else if (e8 <= 8'd142) begin
            n1_base = {1'b0, 5'(e8 - 8'd112), 10'd0};
            n1_sh = 5'd13;
        end else if (e8 < SGL_EXP_MAX) begin
            n1_base = HALF_INF;
            n1_sh = 5'd24;
        end else begin
            n1_base = HALF_INF;
            n1_sh = 5'd13;
        end
        hm = i_operand_bits[9:0];
        n1_p = 4'd0;
        for (int k = 0; k < 10; k++) begin
            if (hm[k]) n1_p = 4'(k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv1) begin
            r_v1 <= i_valid;
        end
        if (adv1) begin
            r1_func <= i_func;
            r1_x    <= i_operand_bits;
            r1_sh   <= n1_sh;
            r1_base <= n1_base;
            r1_p    <= n1_p;
        end
    end

    // stage 2: shift
    logic [1:0]  r2_func;
    logic [31:0] r2_x;
    logic [15:0] r2_hbase;
    logic [15:0] r2_hmant;
    logic [7:0]  r2_sexp;
    logic [22:0] r2_smant;
    logic [22:0] n2_smant;
    logic [7:0]  n2_sexp;
    logic [4:0]  he;

    always_comb begin
        he = r1_x[14:10];
        if (he == 5'd0) begin
            n2_sexp  = (r1_x[9:0] == 10'd0) ? 8'd0 : 8'(r1_p + 4'd0) + 8'd103;
            n2_smant = 23'({r1_x[9:0], 13'd0} << (4'd10 - r1_p)) & SGL_MANT;
        end else if (he == 5'h1F) begin
            n2_sexp  = SGL_EXP_MAX;
            n2_smant = {r1_x[9:0], 13'd0};
        end else begin
            n2_sexp  = 8'(he) + 8'd112;
            n2_smant = {r1_x[9:0], 13'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv2) begin
            r_v2 <= r_v1;
        end
        if (adv2) begin
            r2_func  <= r1_func;
            r2_x     <= r1_x;
            r2_hbase <= {r1_x[31], 15'd0} | r1_base;
            r2_hmant <= 16'(r1_x[22:0] >> r1_sh);
            r2_sexp  <= n2_sexp;
            r2_smant <= n2_smant;
        end
    end

    // stage 3: assemble
    logic [31:0] r3_res;
    logic [31:0] n3_res;
    logic [15:0] hsum;

    always_comb begin
        hsum = r2_hbase + r2_hmant;
        unique case (t_func'(r2_func))
            FUNC_S2H:  n3_res = {16'd0, hsum};
            FUNC_H2S:  n3_res = {r2_x[15], r2_sexp, r2_smant};
            FUNC_S2BF: n3_res = {16'd0, r2_x[31:16]};
            FUNC_BF2S: n3_res = {r2_x[15:0], 16'd0};
            default:   n3_res = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (adv3) begin
            r_v3 <= r_v2;
        end
        if (adv3) begin
            r3_res <= n3_res;
        end
    end

    assign o_result_bits = r3_res;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_result_bits)))
        else $error("output beat changed while stalled");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_ready) |-> (r_v1 && r_v2 && r_v3 && !i_ready))
        else $error("input stalled with room in pipeline");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !r_v3) |=> r_v3)
        else $error("beat lost between stages");

endmodule

>>> sim/float_format_converter_checker.sv
// Checker for the float format converter: predicts each result from the input beats
// and compares it with the output beats. Depends on ffc_pkg.
module float_format_converter_checker
    import ffc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_operand_bits,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_result_bits,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] expected_results[$];

    function automatic logic [31:0] single_to_half(logic [31:0] x);
        logic [31:0] sign;
        logic [31:0] mant;
        logic [31:0] base;
        int e;
        int sh;
        sign = {16'h0, x[31], 15'h0};
        mant = {9'h0, x[22:0]};
        e = int'(x[30:23]) - 127;
        if (e < -24) begin
            base = 0;
            sh = 24;
        end else if (e < -14) begin
            base = 32'h400 >> (-e - 14);
            sh = -e - 1;
        end else if (e <= 15) begin
            base = 32'(e + 15) << 10;
            sh = 13;
        end else if (e < 128) begin
            base = 32'h7C00;
            sh = 24;
        end else begin
            base = 32'h7C00;
            sh = 13;
        end
        return ((sign | base) + (mant >> sh)) & 32'hFFFF;
    endfunction

    function automatic logic [31:0] half_to_single(logic [15:0] x);
        logic [31:0] sign;
        logic [4:0] ebits;
        logic [31:0] m;
        int p;
        sign = {x[15], 31'h0};
        ebits = x[14:10];
        m = {22'h0, x[9:0]};
        if (ebits == 0) begin
            if (m == 0) return sign;
            p = 9;
            while (m[p] == 1'b0) p--;
            return sign | (32'(p + 103) << 23) | ((m << (23 - p)) & 32'h7FFFFF);
        end
        if (ebits == 5'd31) return sign | 32'h7F800000 | (m << 13);
        return sign | (32'(ebits + 112) << 23) | (m << 13);
    endfunction

    function automatic logic [31:0] convert(t_func f, logic [31:0] x);
        case (f)
            FUNC_S2H:  return single_to_half(x);
            FUNC_H2S:  return half_to_single(x[15:0]);
            FUNC_S2BF: return {16'h0, x[31:16]};
            default:   return {x[15:0], 16'h0};
        endcase
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n)
            o_fail_count <= 0;
        if (i_rst_n && i_valid && i_ready_in)
            expected_results.push_back(convert(t_func'(i_func), i_operand_bits));
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected beat: result_bits %h", i_result_bits);
                o_fail_count <= o_fail_count + 1;
            end else begin
                want = expected_results.pop_front();
                if (want !== i_result_bits) begin
                    $error("result_bits: expected %h, actual %h", want, i_result_bits);
                    o_fail_count <= o_fail_count + 1;
                end
            end
        end
    end
endmodule

>>> sim/float_format_converter_test.sv
// Testbench top for the float format converter: clock, reset, stimulus and verdict.
// Depends on ffc_pkg, float_format_converter and float_format_converter_checker.
module float_format_converter_test;
    import ffc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  func = 2'd0;
    logic [31:0] operand = 32'h0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] result;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          cycle_count = 0;

    always #4 clk = ~clk;

    float_format_converter u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_func(func), .i_operand_bits(operand), .o_valid(out_valid),
        .i_ready(out_ready), .o_result_bits(result)
    );

    float_format_converter_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_ready_in(in_ready),
        .i_func(func), .i_operand_bits(operand), .i_out_valid(out_valid),
        .i_out_ready(out_ready), .i_result_bits(result),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("float_format_converter_test: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic send_beat(t_func f, logic [31:0] x);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        func <= f;
        operand <= x;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic logic [31:0] random_operand();
        logic [31:0] x;
        x = $urandom;
        case ($urandom_range(5))
            0: x[30:23] = 8'hFF;
            1: x[30:23] = 8'd0;
            2: x[30:23] = 8'($urandom_range(127 - 26, 127 - 13));
            3: x[30:23] = 8'($urandom_range(127 + 13, 127 + 17));
            4: x[14:10] = 5'($urandom_range(1) ? 0 : 31);
            default: ;
        endcase
        return x;
    endfunction

    initial begin
        logic [31:0] directed[$];
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed = '{32'h00000000, 32'hFFFFFFFF, 32'h80000000, 32'h7F800000,
                     32'hFF800000, 32'h7F801FFF, 32'h7FC00000, 32'h38800000,
                     32'h38000000, 32'h33800000, 32'h33000000, 32'h477FFFFF,
                     32'h47800000, 32'hC7800000, 32'h3F801FFF, 32'hABCD0001,
                     32'h12347C00, 32'h0000FC00, 32'h00008000, 32'h000003FF};
        foreach (directed[k])
            send_beat(t_func'(k % 4), directed[k]);
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                3: begin send_idle_pct = 37; recv_stall_pct = 37; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int n = 0; n < 360; n++) begin
                if (n == 180) begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (pending != 0) @(posedge clk);
                end
                send_beat(t_func'($urandom_range(3)), random_operand());
            end
        end
        in_valid <= 1'b0;
        recv_stall_pct = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("float_format_converter_test: done, clean");
        else
            $display("float_format_converter_test: done, errors");
        $finish;
    end
endmodule

>>> float_format_converter.f
rtl/ffc_pkg.sv
rtl/float_format_converter.sv
sim/float_format_converter_checker.sv
sim/float_format_converter_test.sv
